/* src/spit_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spit_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CountOutW = 6;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_QUERY  = 1'b1
  } action_t;

  typedef logic signed [CoordW-1:0] coord_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   ins;
    coord_t x;
    coord_t y;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* src/spit_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module spit_cell
  import spit_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 6
) (
  input  wire logic             clk,
  input  wire cell_cmd_t        cmd,
  input  wire logic [CNT_W-1:0] count,
  input  wire coord_t           left_x,
  input  wire coord_t           left_y,
  input  wire logic             left_stay,
  output coord_t                x,
  output coord_t                y,
  output logic                  stay
);

  coord_t x_r, x_nxt;
  coord_t y_r, y_nxt;
  logic   occ;

  assign occ  = count > CNT_W'(IDX);
  // entry keeps its place when it is in use and not above the new x
  assign stay = occ && (x_r <= cmd.x);

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (cmd.ins && !stay) begin
      if (left_stay) begin
        x_nxt = cmd.x;
        y_nxt = cmd.y;
      end else begin
        x_nxt = left_x;
        y_nxt = left_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign x = x_r;
  assign y = y_r;

endmodule

`default_nettype wire

/* src/sorted_point_insert_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake          payload
// in_      in   in_tvalid/tready   tuser: action; tdata: x_coord, y_coord
// out_     out  out_tvalid/tready  tdata: accepted, in_range, point_count
//
// one word per cycle: every cell compares its x with the new x and either
// keeps its entry, loads the new point or takes its left neighbor's, all in
// the same edge. the result sits in an output register from the next cycle on.
// rst_n clears the fill count and the output valid; the stored points are
// left as they are. a stalled output holds the input off until it is taken.
module sorted_point_insert_table
  import spit_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // x_coord[31:0], y_coord[63:32]
  input  wire logic        in_tuser,   // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // accepted[0], in_range[1], point_count[7:2]
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_r, count_nxt;
  coord_t          last_x_r, last_x_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_data_r, out_data_nxt;

  logic      acc, full, ins, rng;
  action_t   action;
  coord_t    in_x, in_y;
  cell_cmd_t cmd;

  coord_t cx    [CAPACITY];
  coord_t cy    [CAPACITY];
  logic   cstay [CAPACITY];

  assign action    = action_t'(in_tuser);
  assign in_x      = in_tdata[31:0];
  assign in_y      = in_tdata[63:32];
  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign full      = count_r == CntW'(CAPACITY);
  assign ins       = acc && (action == ACT_INSERT) && !full;

  assign cmd.ins = ins;
  assign cmd.x   = in_x;
  assign cmd.y   = in_y;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      spit_cell #(.IDX(i), .CNT_W(CntW)) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .count     (count_r),
        .left_x    (in_x),
        .left_y    (in_y),
        .left_stay (1'b1),
        .x         (cx[i]),
        .y         (cy[i]),
        .stay      (cstay[i])
      );
    end else begin : g_body
      spit_cell #(.IDX(i), .CNT_W(CntW)) u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .count     (count_r),
        .left_x    (cx[i-1]),
        .left_y    (cy[i-1]),
        .left_stay (cstay[i-1]),
        .x         (cx[i]),
        .y         (cy[i]),
        .stay      (cstay[i])
      );
    end
  end

  assign rng = (count_r != '0) && (cx[0] <= in_x) && (in_x <= last_x_r);

  always_comb begin
    count_nxt     = count_r;
    last_x_nxt    = last_x_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (ins) begin
      count_nxt = count_r + CntW'(1);
      // equal x goes after the stored ones, so the new point may become last
      if ((count_r == '0) || (in_x >= last_x_r)) begin
        last_x_nxt = in_x;
      end
    end
    if (acc) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {CountOutW'(count_nxt),
                       (action == ACT_QUERY) && rng,
                       ins};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_x_r   <= last_x_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* dv/tb_sorted_point_insert_table.sv */
`timescale 1ns / 1ps

module tb_sorted_point_insert_table;
  import spit_pkg::*;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomItems = 1200;

  typedef struct packed {
    logic                 accepted;
    logic                 in_range;
    logic [CountOutW-1:0] point_count;
  } table_reply_t;

  // sorted copy of the point table plus the replies it still owes
  class point_table_model;
    coord_t       x_keys[$];
    coord_t       y_vals[$];
    table_reply_t owed_replies[$];
    int           errors;
    int           n_stored;
    int           n_refused;
    int           n_queries;
    int           n_hits;

    function void take_item(action_t act, coord_t x, coord_t y);
      table_reply_t r;
      int           pos;
      r = '0;
      pos = 0;
      if (act == ACT_INSERT) begin
        if (x_keys.size() < TableDepth) begin
          // equal keys keep arrival order: go past every x <= new x
          while (pos < x_keys.size() && x_keys[pos] <= x) pos++;
          x_keys.insert(pos, x);
          y_vals.insert(pos, y);
          r.accepted = 1'b1;
          n_stored++;
        end else begin
          n_refused++;
        end
      end else begin
        n_queries++;
        if (x_keys.size() > 0 && x_keys[0] <= x && x <= x_keys[x_keys.size()-1]) begin
          r.in_range = 1'b1;
          n_hits++;
        end
      end
      r.point_count = CountOutW'(x_keys.size());
      owed_replies.push_back(r);
    endfunction

    function void check_reply(logic [7:0] word);
      table_reply_t want;
      if (owed_replies.size() == 0) begin
        $error("result word %h arrived with nothing outstanding", word);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      if (word[0] !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, word[0]);
        errors++;
      end
      if (word[1] !== want.in_range) begin
        $error("in_range: expected %0d, got %0d", want.in_range, word[1]);
        errors++;
      end
      if (word[7:2] !== want.point_count) begin
        $error("point_count: expected %0d, got %0d", want.point_count, word[7:2]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  point_table_model table_model = new();
  int unsigned      idle_pct;
  int unsigned      stall_pct;
  int unsigned      items_left;
  int unsigned      quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sorted_point_insert_table #(.CAPACITY(TableDepth)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // inputs are noted before results so a word accepted this edge is already owed
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        table_model.take_item(action_t'(in_tuser), coord_t'(in_tdata[31:0]),
                              coord_t'(in_tdata[63:32]));
      if (out_tvalid && out_tready) table_model.check_reply(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_sorted_point_insert_table failed");
        $finish;
      end
    end
  end

  task automatic send_word(action_t act, coord_t x, coord_t y);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  // one edge first so the word accepted at the last edge is already owed
  task automatic drain_table;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (table_model.owed_replies.size() != 0);
  endtask

  // mix of extremes, values around zero, neighbors of stored keys and anything at all
  function automatic coord_t pick_x();
    int unsigned sel;
    int unsigned n;
    coord_t      x;
    sel = $urandom_range(7);
    n = table_model.x_keys.size();
    case (sel)
      0: x = coord_t'(32'h7fff_ffff);
      1: x = coord_t'(32'h8000_0000);
      2: x = coord_t'($urandom_range(2)) - coord_t'(1);
      3, 4: begin
        if (n > 0)
          x = table_model.x_keys[$urandom_range(n - 1)] + coord_t'($urandom_range(2))
              - coord_t'(1);
        else
          x = coord_t'($urandom);
      end
      default: x = coord_t'($urandom);
    endcase
    return x;
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned free_slots;
    action_t     act;
    repeat (count) begin
      free_slots = TableDepth - table_model.x_keys.size();
      // fill the table slowly, but make sure it is full well before the end
      if (free_slots > 0 && (items_left <= free_slots + 200 || $urandom_range(15) == 0))
        act = ACT_INSERT;
      else if (free_slots == 0 && $urandom_range(3) == 0)
        act = ACT_INSERT;
      else
        act = ACT_QUERY;
      send_word(act, pick_x(), coord_t'($urandom));
      if (items_left > 0) items_left--;
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= ACT_INSERT;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    items_left = RandomItems;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table queries
    send_word(ACT_QUERY,  coord_t'(0),            coord_t'(0));
    send_word(ACT_QUERY,  coord_t'(32'h8000_0000), coord_t'(32'hffff_ffff));
    send_word(ACT_QUERY,  coord_t'(32'h7fff_ffff), coord_t'(0));
    // single point, then the extremes on both ends
    send_word(ACT_INSERT, coord_t'(0),            coord_t'(32'h7fff_ffff));
    send_word(ACT_QUERY,  coord_t'(0),            coord_t'(0));
    send_word(ACT_QUERY,  coord_t'(1),            coord_t'(0));
    send_word(ACT_QUERY,  coord_t'(-1),           coord_t'(0));
    send_word(ACT_INSERT, coord_t'(32'h7fff_ffff), coord_t'(32'h8000_0000));
    send_word(ACT_INSERT, coord_t'(32'h8000_0000), coord_t'(0));
    send_word(ACT_QUERY,  coord_t'(32'h8000_0000), coord_t'(0));
    send_word(ACT_QUERY,  coord_t'(32'h7fff_ffff), coord_t'(0));
    send_word(ACT_QUERY,  coord_t'(0),            coord_t'(0));
    // equal keys
    send_word(ACT_INSERT, coord_t'(0),            coord_t'(32'h5555_aaaa));
    send_word(ACT_INSERT, coord_t'(32'h8000_0000), coord_t'(32'haaaa_5555));
    send_word(ACT_INSERT, coord_t'(32'h7fff_ffff), coord_t'(32'hffff_ffff));
    send_word(ACT_QUERY,  coord_t'(32'h8000_0001), coord_t'(0));
    send_word(ACT_QUERY,  coord_t'(32'h7fff_fffe), coord_t'(0));
    send_word(ACT_INSERT, coord_t'(-1),           coord_t'(32'h0001_0000));
    send_word(ACT_INSERT, coord_t'(1),            coord_t'(32'hffff_0000));
    send_word(ACT_QUERY,  coord_t'(1),            coord_t'(0));
    drain_table();

    idle_pct = 0;  stall_pct = 0;  run_random(300); drain_table();
    idle_pct = 50; stall_pct = 0;  run_random(300); drain_table();
    idle_pct = 0;  stall_pct = 50; run_random(300); drain_table();
    idle_pct = 11; stall_pct = 11; run_random(300); drain_table();
    repeat (10) @(posedge clk);

    $display("covered %0d stored inserts, %0d inserts refused on a full table",
             table_model.n_stored, table_model.n_refused);
    $display("and %0d range queries, %0d of them inside the stored span",
             table_model.n_queries, table_model.n_hits);
    if (table_model.errors == 0 && table_model.owed_replies.size() == 0) begin
      $display("tb_sorted_point_insert_table passed");
    end else begin
      $display("tb_sorted_point_insert_table failed");
    end
    $finish;
  end

endmodule
